>>> sv/bssf_pkg.sv
// Shared types, codes and constants for the bitmap strip span fill block.
`timescale 1ns / 1ps

package bssf_pkg;

  localparam int ROWS_DEF       = 64;
  localparam int LINE_BYTES_DEF = 256;

  // Width for line-length and row range compares; covers every legal parameter value.
  localparam int CW = 16;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_SPAN  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  localparam logic [1:0] POL_DARK   = 2'd0;
  localparam logic [1:0] POL_CLEAR  = 2'd1;
  localparam logic [1:0] POL_INVERT = 2'd2;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  localparam logic [1:0] CFG_LINE_BYTES = 2'd0;
  localparam logic [1:0] CFG_IMAGE_DARK = 2'd1;
  localparam logic [1:0] CFG_COUNT_AREA = 2'd2;

  localparam logic [7:0] TAIL_MASK [8] = '{8'h80, 8'hC0, 8'hE0, 8'hF0,
                                           8'hF8, 8'hFC, 8'hFE, 8'hFF};
  localparam logic [7:0] HEAD_MASK [8] = '{8'hFF, 8'h7F, 8'h3F, 8'h1F,
                                           8'h0F, 8'h07, 8'h03, 8'h01};
  localparam logic [7:0] FILL_LIGHT = 8'hFF;
  localparam logic [7:0] FILL_DARK  = 8'h00;

  typedef struct packed {
    logic load;
    logic decode;
    logic clr_step;
    logic span_step;
    logic drain;
    logic rd_take;
    logic finish;
  } bssf_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       bad;
    logic       skip;
    logic       clr_last;
    logic       span_last;
    logic       out_free;
  } bssf_stat_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

>>> sv/bssf_if.sv
// Input and result channel interfaces for the bitmap strip span fill block.
`timescale 1ns / 1ps

interface bssf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  row;
  logic [10:0] x_start;
  logic [10:0] x_end;
  logic [1:0]  polarity;
  logic [7:0]  byte_index;

  modport source (output valid, kind, row, x_start, x_end, polarity, byte_index,
                  input ready);
  modport sink (input valid, kind, row, x_start, x_end, polarity, byte_index,
                output ready);
endinterface

interface bssf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [31:0] dark_count;
  logic        status;

  modport source (output valid, read_byte, dark_count, status, input ready);
  modport sink (input valid, read_byte, dark_count, status, output ready);
endinterface

>>> sv/bssf_ctrl.sv
// Sequencer for clear, span, read and count items of the strip store.
`timescale 1ns / 1ps

module bssf_ctrl import bssf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output bssf_cmd_t  cmd,
  input  bssf_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_SPAN, S_DRAIN, S_RD, S_RD_TAKE, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_CLEAR: state_nxt = S_CLEAR;
          KIND_SPAN:  state_nxt = (stat.bad || stat.skip) ? S_DONE : S_SPAN;
          KIND_READ:  state_nxt = stat.bad ? S_DONE : S_RD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_SPAN: begin
        if (stat.span_last) state_nxt = S_DRAIN;
      end
      S_DRAIN:   state_nxt = S_DONE;
      S_RD:      state_nxt = S_RD_TAKE;
      S_RD_TAKE: state_nxt = S_DONE;
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.decode    = (state_r == S_DECODE);
    cmd.clr_step  = (state_r == S_CLEAR);
    cmd.span_step = (state_r == S_SPAN);
    cmd.drain     = (state_r == S_DRAIN);
    cmd.rd_take   = (state_r == S_RD_TAKE);
    cmd.finish    = (state_r == S_DONE) && stat.out_free;
  end

endmodule

>>> sv/bssf_dpath.sv
// Strip memory, span decode, byte mask pipeline, dark count and result register.
`timescale 1ns / 1ps

module bssf_dpath import bssf_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bssf_cmd_t   cmd,
  output bssf_stat_t  stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_row,
  input  logic [10:0] in_x_start,
  input  logic [10:0] in_x_end,
  input  logic [1:0]  in_polarity,
  input  logic [7:0]  in_byte_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic [31:0] out_dark_count,
  output logic        out_status
);

  localparam int STORE = ROWS * LINE_BYTES;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

  // configuration
  logic [8:0] line_bytes_r;
  logic       image_dark_r;
  logic       count_area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= 9'd256;
      image_dark_r <= 1'b1;
      count_area_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_BYTES: line_bytes_r <= cfg_wdata;
        CFG_IMAGE_DARK: image_dark_r <= cfg_wdata[0];
        CFG_COUNT_AREA: count_area_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  kind_r;
  logic [5:0]  row_r;
  logic [10:0] xs_r;
  logic [10:0] xe_r;
  logic [1:0]  pol_in_r;
  logic [7:0]  bi_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      row_r    <= in_row;
      xs_r     <= in_x_start;
      xe_r     <= in_x_end;
      pol_in_r <= in_polarity;
      bi_r     <= in_byte_index;
    end
  end

  // decode
  logic [10:0]   lo, hi;
  logic [7:0]    first, last;
  logic [CW-1:0] line_len, lb_ext;
  logic          row_bad, span_bad, read_bad;
  logic [1:0]    pol_eff;

  always_comb begin
    lo       = (xs_r > xe_r) ? xe_r : xs_r;
    hi       = (xs_r > xe_r) ? xs_r : xe_r;
    first    = lo[10:3];
    last     = hi[10:3];
    lb_ext   = CW'(line_bytes_r);
    line_len = (lb_ext > CW'(LINE_BYTES)) ? CW'(LINE_BYTES) : lb_ext;
    row_bad  = CW'(row_r) >= CW'(ROWS);
    span_bad = row_bad || (CW'(last) >= line_len);
    read_bad = row_bad || (CW'(bi_r) >= line_len);
    // dark on a light image clears, clear on a dark image sets
    if (pol_in_r == POL_DARK && !image_dark_r) begin
      pol_eff = POL_CLEAR;
    end else if (pol_in_r == POL_CLEAR && image_dark_r) begin
      pol_eff = POL_DARK;
    end else begin
      pol_eff = pol_in_r;
    end
  end

  logic [2:0]    lo3_r, hi3_r;
  logic [7:0]    first_r, last_r, bcur_r;
  logic [1:0]    pol_r;
  logic          st_r;
  logic [AW-1:0] base_r, caddr_r;
  logic [7:0]    rd_r;
  logic [7:0]    rdata_r;

  // span pipeline: read a byte, then write it back modified in the next cycle
  logic          p_vld_r;
  logic [AW-1:0] p_addr_r;
  logic [7:0]    p_mask_r;
  logic [7:0]    mask_cur;
  logic [AW-1:0] raddr;

  assign mask_cur = ((bcur_r == first_r) ? HEAD_MASK[lo3_r] : 8'hFF) &
                    ((bcur_r == last_r)  ? TAIL_MASK[hi3_r] : 8'hFF);
  assign raddr    = base_r + AW'(bcur_r);

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      lo3_r   <= lo[2:0];
      hi3_r   <= hi[2:0];
      first_r <= first;
      last_r  <= last;
      pol_r   <= pol_eff;
      base_r  <= AW'(32'(row_r) * LINE_BYTES);
      bcur_r  <= (kind_r == KIND_READ) ? bi_r : first;
      caddr_r <= '0;
      rd_r    <= 8'd0;
      st_r    <= ((kind_r == KIND_SPAN) && span_bad) ||
                 ((kind_r == KIND_READ) && read_bad);
    end else begin
      if (cmd.clr_step) caddr_r <= caddr_r + AW'(1);
      if (cmd.span_step) begin
        bcur_r   <= bcur_r + 8'd1;
        p_addr_r <= raddr;
        p_mask_r <= mask_cur;
      end
      if (cmd.rd_take) rd_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (cmd.span_step) begin
      p_vld_r <= 1'b1;
    end else if (cmd.drain) begin
      p_vld_r <= 1'b0;
    end
  end

  // strip memory
  logic [7:0]    mem [STORE];
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata, modified;

  always_comb begin
    case (pol_r)
      POL_DARK:   modified = rdata_r | p_mask_r;
      POL_CLEAR:  modified = rdata_r & ~p_mask_r;
      POL_INVERT: modified = rdata_r ^ p_mask_r;
      default:    modified = rdata_r;
    endcase
  end

  assign we    = cmd.clr_step || ((cmd.span_step || cmd.drain) && p_vld_r);
  assign waddr = cmd.clr_step ? caddr_r : p_addr_r;
  assign wdata = cmd.clr_step ? (image_dark_r ? FILL_DARK : FILL_LIGHT) : modified;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // dark count and result register
  logic [31:0] dark_r, dark_nxt;
  logic [32:0] sum;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_count_r;
  logic        out_status_r;

  always_comb begin
    sum      = {1'b0, dark_r} + 33'(pop8(rd_r));
    dark_nxt = dark_r;
    if (kind_r == KIND_ZERO) begin
      dark_nxt = 32'd0;
    end else if (kind_r == KIND_READ && !st_r && count_area_r) begin
      dark_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        dark_r      <= dark_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_byte_r   <= rd_r;
      out_count_r  <= dark_nxt;
      out_status_r <= st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_byte  = out_byte_r;
  assign out_dark_count = out_count_r;
  assign out_status     = out_status_r;

  always_comb begin
    stat           = '0;
    stat.kind      = kind_r;
    stat.bad       = (kind_r == KIND_SPAN) ? span_bad : read_bad;
    stat.skip      = (pol_eff == POL_UNUSED);
    stat.clr_last  = (caddr_r == AW'(STORE - 1));
    stat.span_last = (bcur_r == last_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

>>> sv/bitmap_strip_span_fill.sv
// Top level of the bitmap strip span fill block.
//
// One item is in work at a time; the result sits in an output register, so the
// next item is taken while it waits. Each item passes through decode and ends in
// a done step that waits for the result register. A span over bytes first..last
// takes one span step per byte and a drain step, as the strip memory moves one
// byte a cycle through a read then modify-write pipeline; a read takes a read and
// a take step (one registered memory read); a flagged item, a zero-count item or
// a span with polarity 3 goes from decode straight to done; a clear walks every
// byte of the memory, all ROWS * LINE_BYTES of them. The strip memory has no
// reset: issue a clear before drawing or reading. Configuration writes are taken
// at any edge with cfg_we high and must only come while no item is in work.
`timescale 1ns / 1ps

module bitmap_strip_span_fill import bssf_pkg::*; #(
  parameter int ROWS       = ROWS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_wdata,
  bssf_in_if.sink      in_ch,
  bssf_out_if.source   out_ch
);

  bssf_cmd_t  cmd;
  bssf_stat_t stat;
  logic       ready;

  bssf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bssf_dpath #(
    .ROWS       (ROWS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_ch.kind),
    .in_row         (in_ch.row),
    .in_x_start     (in_ch.x_start),
    .in_x_end       (in_ch.x_end),
    .in_polarity    (in_ch.polarity),
    .in_byte_index  (in_ch.byte_index),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_byte  (out_ch.read_byte),
    .out_dark_count (out_ch.dark_count),
    .out_status     (out_ch.status)
  );

  assign in_ch.ready = ready;

  // one item in work: no second transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

  // a result appears only when an item finishes
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // datapath steps are mutually exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.decode, cmd.clr_step, cmd.span_step,
              cmd.drain, cmd.rd_take, cmd.finish}))
    else $error("more than one datapath command active");

  // finishing never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before transfer");

endmodule

>>> tb/sv/bitmap_strip_span_fill_test.sv
// Self-checking testbench for the bitmap strip span fill block.
`timescale 1ns / 1ps

module bitmap_strip_span_fill_test;
  import bssf_pkg::*;

  localparam int STORE_BYTES   = ROWS_DEF * LINE_BYTES_DEF;
  // A clear walks the whole store; leave room for it plus receiver stalls.
  localparam int QUIET_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 8;

  localparam logic [8:0] PHASE_LB [NUM_PHASES] = '{9'd256, 9'd1, 9'd0, 9'd511,
                                                   9'd37, 9'd256, 9'd300, 9'd8};
  localparam logic PHASE_DARK [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                               1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic PHASE_COUNT [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1,
                                                1'b0, 1'b1, 1'b1, 1'b0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{170, 170, 40, 170, 170, 190, 200, 190};

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  row;
    logic [10:0] x_start;
    logic [10:0] x_end;
    logic [1:0]  polarity;
    logic [7:0]  byte_index;
  } strip_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [31:0] dark_count;
    logic        status;
  } strip_result_t;

  class span_fill_scoreboard;
    logic [7:0]    strip [STORE_BYTES];
    logic [8:0]    line_bytes;
    logic          image_dark;
    logic          count_area;
    logic [31:0]   dark_pixels;
    strip_result_t expected_q [$];
    int            errors;

    function new();
      line_bytes  = 9'd256;
      image_dark  = 1'b1;
      count_area  = 1'b0;
      dark_pixels = '0;
      errors      = 0;
      foreach (strip[i]) strip[i] = 8'h00;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [8:0] val);
      case (idx)
        CFG_LINE_BYTES: line_bytes = val;
        CFG_IMAGE_DARK: image_dark = val[0];
        CFG_COUNT_AREA: count_area = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned line_len();
      return (line_bytes > LINE_BYTES_DEF) ? LINE_BYTES_DEF : int'(line_bytes);
    endfunction

    function void modify(input int unsigned addr, input logic [7:0] mask,
                         input logic [1:0] pol);
      case (pol)
        POL_DARK:   strip[addr] = strip[addr] | mask;
        POL_CLEAR:  strip[addr] = strip[addr] & ~mask;
        POL_INVERT: strip[addr] = strip[addr] ^ mask;
        default: ;
      endcase
    endfunction

    function void note_item(input strip_item_t it);
      strip_result_t r;
      int unsigned   lo, hi, first, last, base, len, n;
      logic [1:0]    pol;
      logic [7:0]    mask, v;
      r   = '0;
      len = line_len();
      case (it.kind)
        KIND_CLEAR: begin
          foreach (strip[i]) strip[i] = image_dark ? 8'h00 : 8'hFF;
        end
        KIND_SPAN: begin
          lo = it.x_start;
          hi = it.x_end;
          if (lo > hi) begin
            lo = it.x_end;
            hi = it.x_start;
          end
          first = lo / 8;
          last  = hi / 8;
          if (it.row >= ROWS_DEF || last >= len) begin
            r.status = 1'b1;
          end else begin
            pol = it.polarity;
            // dark and clear swap meaning with the image background
            if (pol == POL_DARK && !image_dark) pol = POL_CLEAR;
            else if (pol == POL_CLEAR && image_dark) pol = POL_DARK;
            base = it.row * LINE_BYTES_DEF;
            for (int unsigned b = first; b <= last; b++) begin
              mask = 8'hFF;
              if (b == first) mask = mask & (8'hFF >> (lo % 8));
              if (b == last) mask = mask & 8'(8'hFF << (7 - hi % 8));
              modify(base + b, mask, pol);
            end
          end
        end
        KIND_READ: begin
          if (it.row >= ROWS_DEF || it.byte_index >= len) begin
            r.status = 1'b1;
          end else begin
            v = strip[it.row * LINE_BYTES_DEF + it.byte_index];
            r.read_byte = v;
            if (count_area) begin
              n = $countones(v);
              dark_pixels = (dark_pixels > 32'hFFFF_FFFF - n) ? 32'hFFFF_FFFF
                                                               : dark_pixels + n;
            end
          end
        end
        default: dark_pixels = '0;
      endcase
      r.dark_count = dark_pixels;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(input strip_result_t got);
      strip_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: read_byte %0h dark_count %0d status %0d",
               got.read_byte, got.dark_count, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte);
        errors++;
      end
      if (got.dark_count !== want.dark_count) begin
        $error("dark_count: expected %0d, got %0d", want.dark_count, got.dark_count);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles   = 0;

  span_fill_scoreboard sb;

  bssf_in_if  in_if ();
  bssf_out_if out_if ();

  bitmap_strip_span_fill u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check results before noting new inputs: a result at this edge belongs to an older item.
  always @(posedge clk) begin : monitor
    strip_result_t got;
    strip_item_t   seen;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.read_byte  = out_if.read_byte;
        got.dark_count = out_if.dark_count;
        got.status     = out_if.status;
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready) begin
        seen.kind       = in_if.kind;
        seen.row        = in_if.row;
        seen.x_start    = in_if.x_start;
        seen.x_end      = in_if.x_end;
        seen.polarity   = in_if.polarity;
        seen.byte_index = in_if.byte_index;
        sb.note_item(seen);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bitmap_strip_span_fill_test: done, errors");
        $finish;
      end
    end
  end

  function automatic strip_item_t mk_item(input logic [1:0] kind, input logic [5:0] row,
                                          input logic [10:0] xs, input logic [10:0] xe,
                                          input logic [1:0] pol, input logic [7:0] bi);
    strip_item_t it;
    it.kind       = kind;
    it.row        = row;
    it.x_start    = xs;
    it.x_end      = xe;
    it.polarity   = pol;
    it.byte_index = bi;
    return it;
  endfunction

  function automatic strip_item_t random_item(input int unsigned len);
    strip_item_t it;
    int unsigned pick, shape, xa, xb, px, tmp;
    pick          = $urandom_range(999);
    it.row        = ($urandom_range(99) < 70) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    it.x_start    = 11'($urandom_range(2047));
    it.x_end      = 11'($urandom_range(2047));
    it.polarity   = ($urandom_range(99) < 6) ? POL_UNUSED : 2'($urandom_range(2));
    it.byte_index = 8'($urandom_range(255));
    if (pick < 8) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 50) begin
      it.kind = KIND_ZERO;
    end else if (pick < 450) begin
      it.kind = KIND_READ;
      if (len != 0 && $urandom_range(99) < 85) it.byte_index = 8'($urandom_range(len - 1));
    end else begin
      it.kind = KIND_SPAN;
      px      = len * 8;
      shape   = $urandom_range(9);
      xa      = it.x_start;
      xb      = it.x_end;
      if (px != 0 && shape == 0) begin
        xa = 0;
        xb = px - 1;
      end else if (px != 0 && shape > 1) begin
        // mostly short spans inside the line, now and then a wide one
        xa = $urandom_range(px - 1);
        xb = xa + $urandom_range(($urandom_range(3) == 0) ? 200 : 24);
        if (xb > px - 1) xb = px - 1;
      end
      if ($urandom_range(2) == 0) begin
        tmp = xa;
        xa  = xb;
        xb  = tmp;
      end
      it.x_start = 11'(xa);
      it.x_end   = 11'(xb);
    end
    return it;
  endfunction

  task automatic send_item(input strip_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.kind       <= it.kind;
    in_if.row        <= it.row;
    in_if.x_start    <= it.x_start;
    in_if.x_end      <= it.x_end;
    in_if.polarity   <= it.polarity;
    in_if.byte_index <= it.byte_index;
    in_if.valid      <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Drop valid, drain every pending result, then give the block a few idle cycles.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [8:0] lb, input logic dark, input logic cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINE_BYTES;
    cfg_wdata <= lb;
    sb.set_reg(CFG_LINE_BYTES, lb);
    @(negedge clk);
    cfg_index <= CFG_IMAGE_DARK;
    cfg_wdata <= {8'd0, dark};
    sb.set_reg(CFG_IMAGE_DARK, {8'd0, dark});
    @(negedge clk);
    cfg_index <= CFG_COUNT_AREA;
    cfg_wdata <= {8'd0, cnt};
    sb.set_reg(CFG_COUNT_AREA, {8'd0, cnt});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_LINE_BYTES;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_CLEAR;
    in_if.row         = '0;
    in_if.x_start     = '0;
    in_if.x_end       = '0;
    in_if.polarity    = POL_DARK;
    in_if.byte_index  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full line, reversed ends, polarity swap on a dark image, unused polarity, count zeroing.
    write_config(9'd256, 1'b1, 1'b1);
    send_item(mk_item(KIND_CLEAR, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd0));
    send_item(mk_item(KIND_SPAN, 6'd0, 11'd0, 11'd2047, POL_DARK, 8'd0));
    send_item(mk_item(KIND_READ, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd0));
    send_item(mk_item(KIND_READ, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd255));
    send_item(mk_item(KIND_SPAN, 6'd63, 11'd13, 11'd3, POL_INVERT, 8'd0));
    send_item(mk_item(KIND_READ, 6'd63, 11'd0, 11'd0, POL_DARK, 8'd0));
    send_item(mk_item(KIND_READ, 6'd63, 11'd0, 11'd0, POL_DARK, 8'd1));
    send_item(mk_item(KIND_SPAN, 6'd63, 11'd2040, 11'd2047, POL_CLEAR, 8'd0));
    send_item(mk_item(KIND_READ, 6'd63, 11'd0, 11'd0, POL_DARK, 8'd255));
    send_item(mk_item(KIND_SPAN, 6'd0, 11'd100, 11'd200, POL_UNUSED, 8'd0));
    send_item(mk_item(KIND_READ, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd12));
    send_item(mk_item(KIND_ZERO, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd0));
    send_item(mk_item(KIND_READ, 6'd63, 11'd0, 11'd0, POL_DARK, 8'd0));
    settle();

    // Short light-background line: spans and reads beyond the line get flagged.
    write_config(9'd4, 1'b0, 1'b1);
    send_item(mk_item(KIND_CLEAR, 6'd0, 11'd0, 11'd0, POL_DARK, 8'd0));
    send_item(mk_item(KIND_SPAN, 6'd7, 11'd26, 11'd5, POL_DARK, 8'd0));
    send_item(mk_item(KIND_SPAN, 6'd7, 11'd0, 11'd32, POL_INVERT, 8'd0));
    send_item(mk_item(KIND_READ, 6'd7, 11'd0, 11'd0, POL_DARK, 8'd4));
    send_item(mk_item(KIND_READ, 6'd7, 11'd0, 11'd0, POL_DARK, 8'd1));
    send_item(mk_item(KIND_SPAN, 6'd7, 11'd31, 11'd31, POL_INVERT, 8'd0));
    send_item(mk_item(KIND_READ, 6'd7, 11'd0, 11'd0, POL_DARK, 8'd3));
    send_item(mk_item(KIND_READ, 6'd7, 11'd0, 11'd0, POL_DARK, 8'd0));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_config(PHASE_LB[phase], PHASE_DARK[phase], PHASE_COUNT[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (PHASE_ITEMS[phase]) send_item(random_item(sb.line_len()));
    end
    settle();

    if (sb.errors == 0) begin
      $display("bitmap_strip_span_fill_test: done, clean");
    end else begin
      $display("bitmap_strip_span_fill_test: done, errors");
    end
    $finish;
  end

endmodule
